### hw/rtl/erfra_pkg.sv
// Shared types, constants and stage map for the erf pipeline.
`default_nettype none

package erfra_pkg;

  localparam int IN_FRAC_BITS  = 12;
  localparam int OUT_FRAC_BITS = 14;
  localparam int DATA_W        = 16;

  localparam longint Q_ONE  = 64'd1073741824;
  localparam longint NANO   = 64'd1000000000;
  localparam longint HALF_N = 64'd500000000;
  localparam longint TWO32  = 64'd4294967296;

  localparam longint A1_MAG = (64'd254829592  * Q_ONE + HALF_N) / NANO;
  localparam longint A2_MAG = (64'd284496736  * Q_ONE + HALF_N) / NANO;
  localparam longint A3_MAG = (64'd1421413741 * Q_ONE + HALF_N) / NANO;
  localparam longint A4_MAG = (64'd1453152027 * Q_ONE + HALF_N) / NANO;
  localparam longint A5_MAG = (64'd1061405429 * Q_ONE + HALF_N) / NANO;
  localparam longint P_MAG  = (64'd327591100  * Q_ONE + HALF_N) / NANO;

  localparam logic signed [33:0] C_A1 = $signed(34'(A1_MAG));
  localparam logic signed [33:0] C_A2 = -$signed(34'(A2_MAG));
  localparam logic signed [33:0] C_A3 = $signed(34'(A3_MAG));
  localparam logic signed [33:0] C_A4 = -$signed(34'(A4_MAG));
  localparam logic signed [33:0] C_A5 = $signed(34'(A5_MAG));
  localparam logic [29:0]        C_P  = 30'(P_MAG);

  localparam logic [36:0] LN2_Q30 = 37'd744261118;
  localparam int          EXP_TERMS = 12;
  localparam int          K_BITS    = 6;

  localparam logic [DATA_W-1:0] BIG_ARG = DATA_W'(6 << IN_FRAC_BITS);
  localparam int SQ_SHIFT  = 30 - 2 * IN_FRAC_BITS;
  localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;
  localparam logic [35:0] ONE_OUT = 36'(1) << OUT_FRAC_BITS;

  // floor(2^32 / n), for the Taylor term division by n
  localparam logic [32:0] RECIP [1:EXP_TERMS] = '{
    33'(TWO32 / 1),  33'(TWO32 / 2),  33'(TWO32 / 3),  33'(TWO32 / 4),
    33'(TWO32 / 5),  33'(TWO32 / 6),  33'(TWO32 / 7),  33'(TWO32 / 8),
    33'(TWO32 / 9),  33'(TWO32 / 10), 33'(TWO32 / 11), 33'(TWO32 / 12)
  };

  localparam logic signed [33:0] HORNER_ADD [5] = '{C_A4, C_A3, C_A2, C_A1, 34'sd0};

  // stage map
  localparam int ST_PRE    = 1;
  localparam int DIV_FIRST = 2;
  localparam int DIV_LAST  = 32;
  localparam int K_FIRST   = 2;
  localparam int K_LAST    = K_FIRST + K_BITS - 1;
  localparam int T_FIRST   = K_LAST + 1;
  localparam int T_LAST    = T_FIRST + 3 * EXP_TERMS - 1;
  localparam int E_ST      = T_LAST + 1;
  localparam int H_FIRST   = DIV_LAST + 1;
  localparam int H_LAST    = H_FIRST + 9;
  localparam int F_MUL     = E_ST + 1;
  localparam int F_OUT     = F_MUL + 1;
  localparam int NST       = F_OUT + 1;

  typedef struct packed {
    logic                vld;
    logic                neg;
    logic                big;
    logic [15:0]         a;
    logic [31:0]         den;
    logic [30:0]         half;
    logic [31:0]         rem;
    logic [30:0]         t;
    logic signed [33:0]  acc;
    logic                hneg;
    logic [63:0]         hprod;
    logic [36:0]         kr;
    logic [K_BITS-1:0]   k;
    logic [30:0]         term;
    logic [60:0]         tprod;
    logic [30:0]         ty;
    logic [63:0]         tym;
    logic [30:0]         sum;
    logic [30:0]         e;
    logic [DATA_W-1:0]   res;
  } stage_t;

endpackage

`default_nettype wire

### hw/rtl/erf_rational_exp_approx_top.sv
// erf(x) by Abramowitz-Stegun 7.1.26, fully pipelined, one beat per cycle unless out_tready stalls.
//
//  port group | dir | payload
//  in_*       | in  | tdata[15:0] = arg_x (signed Q3.12)
//  out_*      | out | tdata[15:0] = erf_value (signed Q1.14)
//
// One beat enters per cycle while out_tready does not stall the pipe.
// The depth is set by the 6-stage ln2 split, the 36-stage Taylor series and the
// exponent shift, run beside the 31-stage reciprocal divider and 10 Horner stages.
// Reset clears the stage valid bits only.
// A stall on out_tready freezes the whole pipe; bubbles travel as invalid stages.
`default_nettype none

module erf_rational_exp_approx_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] arg_x
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [15:0] erf_value
);

  erfra_pkg::stage_t pipe_r   [erfra_pkg::NST];
  erfra_pkg::stage_t pipe_nxt [erfra_pkg::NST];
  logic              en;

  assign en         = !pipe_r[erfra_pkg::F_OUT].vld || out_tready;
  assign in_tready  = en;
  assign out_tvalid = pipe_r[erfra_pkg::F_OUT].vld;
  assign out_tdata  = pipe_r[erfra_pkg::F_OUT].res;

  for (genvar g = 0; g < erfra_pkg::NST; g++) begin : g_stage
    if (g == 0) begin : g_in
      always_comb begin
        pipe_nxt[g]     = '0;
        pipe_nxt[g].vld = in_tvalid;
        pipe_nxt[g].neg = in_tdata[15];
        pipe_nxt[g].a   = in_tdata[15] ? 16'(~in_tdata + 16'd1) : in_tdata;
        pipe_nxt[g].big = pipe_nxt[g].a >= erfra_pkg::BIG_ARG;
      end
    end else begin : g_work
      localparam bit IS_DIV = (g >= erfra_pkg::DIV_FIRST) && (g <= erfra_pkg::DIV_LAST);
      localparam bit IS_K   = (g >= erfra_pkg::K_FIRST) && (g <= erfra_pkg::K_LAST);
      localparam bit IS_T   = (g >= erfra_pkg::T_FIRST) && (g <= erfra_pkg::T_LAST);
      localparam bit IS_H   = (g >= erfra_pkg::H_FIRST) && (g <= erfra_pkg::H_LAST);
      localparam int DBIT   = IS_DIV ? erfra_pkg::DIV_LAST - g : 0;
      localparam int KBIT   = IS_K ? erfra_pkg::K_LAST - g : 0;
      localparam int TN     = IS_T ? (g - erfra_pkg::T_FIRST) / 3 + 1 : 1;
      localparam int TPH    = IS_T ? (g - erfra_pkg::T_FIRST) % 3 : 0;
      localparam int HS     = IS_H ? (g - erfra_pkg::H_FIRST) / 2 : 0;
      localparam int HPH    = IS_H ? (g - erfra_pkg::H_FIRST) % 2 : 0;

      always_comb begin
        erfra_pkg::stage_t st;
        logic [47:0]        pa_w;
        logic [31:0]        sq;
        logic [32:0]        r2;
        logic [36:0]        ksub;
        logic [61:0]        tsum;
        logic [30:0]        yv;
        logic [31:0]        q0;
        logic [34:0]        rm;
        logic [30:0]        tn;
        logic [63:0]        esh;
        logic [32:0]        amag;
        logic [33:0]        rr;
        logic signed [35:0] qe;
        logic signed [35:0] y;
        logic [35:0]        mag;
        logic [15:0]        mag16;

        st    = pipe_r[g-1];
        pa_w  = '0;
        sq    = '0;
        r2    = '0;
        ksub  = '0;
        tsum  = '0;
        yv    = '0;
        q0    = '0;
        rm    = '0;
        tn    = '0;
        esh   = '0;
        amag  = '0;
        rr    = '0;
        qe    = '0;
        y     = '0;
        mag   = '0;
        mag16 = '0;

        if (g == erfra_pkg::ST_PRE) begin
          pa_w    = 48'(erfra_pkg::C_P) * 48'(st.a);
          pa_w    = (pa_w + (48'd1 << (erfra_pkg::IN_FRAC_BITS - 1)))
                    >> erfra_pkg::IN_FRAC_BITS;
          st.den  = 32'(erfra_pkg::Q_ONE) + pa_w[31:0];
          st.half = st.den[31:1];
          st.rem  = 32'd1 << 29;
          sq      = 32'(st.a) * 32'(st.a);
          st.kr   = 37'(sq) << erfra_pkg::SQ_SHIFT;
          st.acc  = erfra_pkg::C_A5;
          st.term = 31'(erfra_pkg::Q_ONE);
          st.sum  = 31'(erfra_pkg::Q_ONE);
        end

        if (IS_DIV) begin
          r2 = {st.rem, st.half[DBIT]};
          if (r2 >= {1'b0, st.den}) begin
            st.rem     = 32'(r2 - {1'b0, st.den});
            st.t[DBIT] = 1'b1;
          end else begin
            st.rem     = r2[31:0];
            st.t[DBIT] = 1'b0;
          end
        end

        if (IS_K) begin
          ksub = erfra_pkg::LN2_Q30 << KBIT;
          if (st.kr >= ksub) begin
            st.kr      = st.kr - ksub;
            st.k[KBIT] = 1'b1;
          end else begin
            st.k[KBIT] = 1'b0;
          end
        end

        if (IS_T) begin
          case (TPH)
            0: begin
              st.tprod = 61'(st.term) * 61'(st.kr[29:0]);
            end
            1: begin
              tsum   = 62'(st.tprod) + (62'(TN) << 29);
              yv     = tsum[60:30];
              st.ty  = yv;
              st.tym = 64'(yv) * 64'(erfra_pkg::RECIP[TN]);
            end
            default: begin
              q0 = st.tym[63:32];
              rm = 35'(st.ty) - 35'(q0) * 35'(TN);
              tn = (rm >= 35'(TN)) ? 31'(q0 + 32'd1) : q0[30:0];
              st.term = tn;
              st.sum  = (TN % 2 == 1) ? st.sum - tn : st.sum + tn;
            end
          endcase
        end

        if (g == erfra_pkg::E_ST) begin
          esh  = (64'(st.sum) + ((64'd1 << st.k) >> 1)) >> st.k;
          st.e = esh[30:0];
        end

        if (IS_H) begin
          if (HPH == 0) begin
            st.hneg  = st.acc[33];
            amag     = st.acc[33] ? 33'(-st.acc) : st.acc[32:0];
            st.hprod = 64'(amag) * 64'(st.t);
          end else begin
            rr     = 34'((st.hprod + 64'd536870912) >> 30);
            st.acc = (st.hneg ? -$signed(rr) : $signed(rr)) + erfra_pkg::HORNER_ADD[HS];
          end
        end

        if (g == erfra_pkg::F_MUL) begin
          st.hneg  = st.acc[33];
          amag     = st.acc[33] ? 33'(-st.acc) : st.acc[32:0];
          st.hprod = 64'(amag) * 64'(st.e);
        end

        if (g == erfra_pkg::F_OUT) begin
          rr = 34'((st.hprod + 64'd536870912) >> 30);
          qe = st.hneg ? -$signed(36'(rr)) : $signed(36'(rr));
          y  = $signed(36'(erfra_pkg::Q_ONE)) - qe;
          if (y < 0) begin
            y = '0;
          end
          mag = (36'(y) + (36'd1 << (erfra_pkg::OUT_SHIFT - 1))) >> erfra_pkg::OUT_SHIFT;
          if (mag > erfra_pkg::ONE_OUT || st.big) begin
            mag = erfra_pkg::ONE_OUT;
          end
          mag16  = mag[15:0];
          st.res = st.neg ? 16'(~mag16 + 16'd1) : mag16;
        end

        pipe_nxt[g] = st;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[g].vld <= 1'b0;
      end else if (en) begin
        pipe_r[g] <= pipe_nxt[g];
      end
    end
  end

  ast_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= $signed(16'(erfra_pkg::ONE_OUT)))
                && ($signed(out_tdata) >= -$signed(16'(erfra_pkg::ONE_OUT))))
    else $error("erf result out of range");

  ast_out_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pipe_r[erfra_pkg::F_OUT].neg ? !($signed(out_tdata) > 0)
                                                  : !out_tdata[15]))
    else $error("erf result sign differs from argument");

  ast_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  ast_ln2_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_r[erfra_pkg::K_LAST].vld && !pipe_r[erfra_pkg::K_LAST].big)
      |-> (pipe_r[erfra_pkg::K_LAST].kr < erfra_pkg::LN2_Q30))
    else $error("ln2 split remainder not reduced");

  ast_recip: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_r[erfra_pkg::DIV_LAST].vld && !pipe_r[erfra_pkg::DIV_LAST].big)
      |-> (pipe_r[erfra_pkg::DIV_LAST].t <= 31'(erfra_pkg::Q_ONE) + 31'd1))
    else $error("reciprocal above one");

endmodule

`default_nettype wire
